### sv/xcff_pkg.sv
// ----------------------------------------------------------------------------
// xcff_pkg: shared constants and types for the XOR-checked frame finder
// Frame layout offsets, length limits, register reset value and the
// sequencer state type.
// ----------------------------------------------------------------------------
package xcff_pkg;

   localparam int FRAME_OVERHEAD = 6;
   localparam int MAX_FRAME_LEN  = 64;

   localparam int LEN_W = 7;
   localparam int K_W   = 6;

   localparam logic [LEN_W-1:0] LEN_OFS   = 7'd1;
   localparam logic [LEN_W-1:0] SEQ_OFS   = 7'd2;
   localparam logic [LEN_W-1:0] STS_OFS   = 7'd3;
   localparam logic [LEN_W-1:0] DEV_OFS   = 7'd4;
   localparam logic [LEN_W-1:0] PARAM_OFS = 7'd5;

   localparam logic [7:0] ACK_HEADER_RESET = 8'hFE;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_HDR     = 13'b0000000000010,
      ST_HDR_CHK = 13'b0000000000100,
      ST_LEN_CHK = 13'b0000000001000,
      ST_SUM     = 13'b0000000010000,
      ST_SUM_END = 13'b0000000100000,
      ST_GET_SEQ = 13'b0000001000000,
      ST_GET_STS = 13'b0000010000000,
      ST_GET_DEV = 13'b0000100000000,
      ST_PRM_RD  = 13'b0001000000000,
      ST_PRM_DAT = 13'b0010000000000,
      ST_SEND    = 13'b0100000000000,
      ST_CLR     = 13'b1000000000000
   } state_type;

endpackage

### sv/xor_checked_frame_finder.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_finder: receive window scanner for XOR-checked frames
// Shifts each received byte into a circular window and rescans it for a
// header/length/XOR-checked reply frame, one window byte read per cycle.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_rx_byte
//   rsp      out        rsp_valid / rsp_stall     seq, status, device, param fields
//   csr      in         csr_write_enable          csr_write_data (ack_header)
//
// The window memory has a single read port. Per item, the byte is written into
// the window; then, for each start tried, the header byte is compared and, on a
// match, the length checked and, if accepted, the XOR checksum taken; a found
// frame has its fields read, its results sent as rsp_stall allows, then is cleared.
// req_stall is high from the accepting edge until the item is fully done.
// Reset is synchronous; it empties the window and sets ack_header to 0xFE.
//
module xor_checked_frame_finder #(
   parameter int WINDOW_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_seq_number,
   output logic [7:0] rsp_status_code,
   output logic [7:0] rsp_device_id,
   output logic [5:0] rsp_param_count,
   output logic [5:0] rsp_param_index,
   output logic [7:0] rsp_param_byte,
   output logic       rsp_last,

   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam int IDX_W      = $clog2(WINDOW_BYTES);
   localparam int SUM_W      = ((IDX_W > 8) ? IDX_W : 8) + 2;
   localparam int LAST_START = WINDOW_BYTES - xcff_pkg::FRAME_OVERHEAD;

   xcff_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]          base_ff, base_in;
   logic [IDX_W-1:0]          start_ff, start_in;
   logic [xcff_pkg::LEN_W-1:0] len_ff, len_in;
   logic [xcff_pkg::K_W-1:0]   k_ff, k_in;
   logic [7:0]                xor_ff, xor_in;
   logic [7:0]                ack_header_ff, ack_header_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_seq_ff, rsp_seq_in;
   logic [7:0] rsp_sts_ff, rsp_sts_in;
   logic [7:0] rsp_dev_ff, rsp_dev_in;
   logic [5:0] rsp_cnt_ff, rsp_cnt_in;
   logic [5:0] rsp_idx_ff, rsp_idx_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic [7:0]              mem_ff [WINDOW_BYTES];
   logic [WINDOW_BYTES-1:0] valid_ff;
   logic [7:0]              rd_data_ff;
   logic                    rd_valid_ff;
   logic [7:0]              rd_byte;

   logic [xcff_pkg::LEN_W-1:0] rd_ofs;
   logic [SUM_W-1:0]           lidx;
   logic [SUM_W-1:0]           phys_sum;
   logic [SUM_W-1:0]           phys;
   logic [IDX_W-1:0]           addr;

   logic             mem_we;
   logic [IDX_W-1:0] waddr;
   logic [7:0]       wdata;

   logic                       req_xfer;
   logic                       at_last_start;
   logic [5:0]                 nparams;
   logic [5:0]                 nres_m1;
   logic [xcff_pkg::LEN_W-1:0] len_m1;

   assign req_xfer      = req_valid && (state_ff == xcff_pkg::ST_IDLE);
   assign at_last_start = (start_ff == IDX_W'(LAST_START));
   assign rd_byte       = rd_valid_ff ? rd_data_ff : 8'd0;
   assign nparams       = 6'(len_ff - xcff_pkg::LEN_W'(xcff_pkg::FRAME_OVERHEAD));
   assign nres_m1       = (nparams == 6'd0) ? 6'd0 : nparams - 6'd1;
   assign len_m1        = len_ff - xcff_pkg::LEN_W'(1);

   // window offset from the current start, per state
   always_comb begin
      unique case (state_ff)
         xcff_pkg::ST_HDR_CHK: rd_ofs = xcff_pkg::LEN_OFS;
         xcff_pkg::ST_SUM,
         xcff_pkg::ST_CLR:     rd_ofs = xcff_pkg::LEN_W'(k_ff);
         xcff_pkg::ST_SUM_END: rd_ofs = xcff_pkg::SEQ_OFS;
         xcff_pkg::ST_GET_SEQ: rd_ofs = xcff_pkg::STS_OFS;
         xcff_pkg::ST_GET_STS: rd_ofs = xcff_pkg::DEV_OFS;
         xcff_pkg::ST_GET_DEV,
         xcff_pkg::ST_PRM_RD:  rd_ofs = xcff_pkg::PARAM_OFS + xcff_pkg::LEN_W'(k_ff);
         default:              rd_ofs = '0;
      endcase
   end

   assign lidx     = SUM_W'(start_ff) + SUM_W'(rd_ofs);
   assign phys_sum = SUM_W'(base_ff) + lidx;
   assign phys     = (phys_sum >= SUM_W'(WINDOW_BYTES)) ?
                     phys_sum - SUM_W'(WINDOW_BYTES) : phys_sum;
   assign addr     = phys[IDX_W-1:0];

   assign mem_we = req_xfer || (state_ff == xcff_pkg::ST_CLR);
   assign waddr  = (state_ff == xcff_pkg::ST_IDLE) ? base_ff : addr;
   assign wdata  = (state_ff == xcff_pkg::ST_IDLE) ? req_rx_byte : 8'd0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      xor_in        = xor_ff;
      ack_header_in = csr_write_enable ? csr_write_data : ack_header_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_sts_in    = rsp_sts_ff;
      rsp_dev_in    = rsp_dev_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         xcff_pkg::ST_IDLE: begin
            if (req_valid) begin
               base_in  = (base_ff == IDX_W'(WINDOW_BYTES - 1)) ? '0 : base_ff + IDX_W'(1);
               start_in = '0;
               state_in = xcff_pkg::ST_HDR;
            end
         end
         xcff_pkg::ST_HDR: begin
            state_in = xcff_pkg::ST_HDR_CHK;
         end
         xcff_pkg::ST_HDR_CHK: begin
            if (rd_byte == ack_header_ff) begin
               state_in = xcff_pkg::ST_LEN_CHK;
            end else if (at_last_start) begin
               state_in = xcff_pkg::ST_IDLE;
            end else begin
               start_in = start_ff + IDX_W'(1);
               state_in = xcff_pkg::ST_HDR;
            end
         end
         xcff_pkg::ST_LEN_CHK: begin
            if (SUM_W'(start_ff) + SUM_W'(rd_byte) > SUM_W'(WINDOW_BYTES)) begin
               state_in = xcff_pkg::ST_IDLE;
            end else if (rd_byte < 8'(xcff_pkg::FRAME_OVERHEAD) ||
                         rd_byte > 8'(xcff_pkg::MAX_FRAME_LEN)) begin
               if (at_last_start) begin
                  state_in = xcff_pkg::ST_IDLE;
               end else begin
                  start_in = start_ff + IDX_W'(1);
                  state_in = xcff_pkg::ST_HDR;
               end
            end else begin
               len_in   = rd_byte[xcff_pkg::LEN_W-1:0];
               k_in     = '0;
               xor_in   = 8'd0;
               state_in = xcff_pkg::ST_SUM;
            end
         end
         xcff_pkg::ST_SUM: begin
            if (k_ff != '0) begin
               xor_in = xor_ff ^ rd_byte;
            end
            if (xcff_pkg::LEN_W'(k_ff) == len_m1) begin
               state_in = xcff_pkg::ST_SUM_END;
            end else begin
               k_in = k_ff + xcff_pkg::K_W'(1);
            end
         end
         xcff_pkg::ST_SUM_END: begin
            k_in = '0;
            if ((xor_ff ^ rd_byte) == 8'd0) begin
               state_in = xcff_pkg::ST_GET_SEQ;
            end else if (at_last_start) begin
               state_in = xcff_pkg::ST_IDLE;
            end else begin
               start_in = start_ff + IDX_W'(1);
               state_in = xcff_pkg::ST_HDR;
            end
         end
         xcff_pkg::ST_GET_SEQ: begin
            rsp_seq_in = rd_byte;
            state_in   = xcff_pkg::ST_GET_STS;
         end
         xcff_pkg::ST_GET_STS: begin
            rsp_sts_in = rd_byte;
            state_in   = xcff_pkg::ST_GET_DEV;
         end
         xcff_pkg::ST_GET_DEV: begin
            rsp_dev_in = rd_byte;
            state_in   = xcff_pkg::ST_PRM_DAT;
         end
         xcff_pkg::ST_PRM_RD: begin
            state_in = xcff_pkg::ST_PRM_DAT;
         end
         xcff_pkg::ST_PRM_DAT: begin
            rsp_cnt_in   = nparams;
            rsp_idx_in   = (nparams == 6'd0) ? 6'd0 : 6'(k_ff);
            rsp_byte_in  = (nparams == 6'd0) ? 8'd0 : rd_byte;
            rsp_last_in  = (6'(k_ff) == nres_m1);
            rsp_valid_in = 1'b1;
            state_in     = xcff_pkg::ST_SEND;
         end
         xcff_pkg::ST_SEND: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  k_in     = '0;
                  state_in = xcff_pkg::ST_CLR;
               end else begin
                  k_in     = k_ff + xcff_pkg::K_W'(1);
                  state_in = xcff_pkg::ST_PRM_RD;
               end
            end
         end
         xcff_pkg::ST_CLR: begin
            if (xcff_pkg::LEN_W'(k_ff) == len_m1) begin
               state_in = xcff_pkg::ST_IDLE;
            end else begin
               k_in = k_ff + xcff_pkg::K_W'(1);
            end
         end
         default: begin
            state_in = xcff_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= xcff_pkg::ST_IDLE;
         base_ff       <= '0;
         ack_header_ff <= xcff_pkg::ACK_HEADER_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         ack_header_ff <= ack_header_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      xor_ff      <= xor_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_sts_ff  <= rsp_sts_in;
      rsp_dev_ff  <= rsp_dev_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall       = (state_ff != xcff_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seq_number  = rsp_seq_ff;
   assign rsp_status_code = rsp_sts_ff;
   assign rsp_device_id   = rsp_dev_ff;
   assign rsp_param_count = rsp_cnt_ff;
   assign rsp_param_index = rsp_idx_ff;
   assign rsp_param_byte  = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
